FILE: rtl/crlf_tok_pkg.sv
// Package for the CR LF line command tokenizer: character codes, the result
// word layout and the command word table with its match function.
// No dependencies.
package crlf_tok_pkg;

    localparam int MAX_LINE_DEFAULT = 512;
    localparam int NUM_WORDS = 19;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W = 2;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] out_byte;
        logic [8:0] token_index;
        logic [4:0] command_code;
        logic [9:0] token_count;
        logic       overflow;
        logic       empty_line;
        logic       last;
    } result_t;

    // Word text is right-justified: the first character is the most
    // significant byte of the used part.
    localparam logic [63:0] WORD_TEXT [NUM_WORDS] = '{
        64'("NICK"), 64'("USER"), 64'("PRIVMSG"), 64'("NOTICE"), 64'("MOTD"),
        64'("LUSERS"), 64'("PING"), 64'("PONG"), 64'("WHOIS"), 64'("QUIT"),
        64'("JOIN"), 64'("PART"), 64'("TOPIC"), 64'("AWAY"), 64'("NAMES"),
        64'("LIST"), 64'("WHO"), 64'("OPER"), 64'("MODE")
    };

    localparam logic [3:0] WORD_LEN [NUM_WORDS] = '{
        4'd4, 4'd4, 4'd7, 4'd6, 4'd4, 4'd6, 4'd4, 4'd4, 4'd5, 4'd4,
        4'd4, 4'd4, 4'd5, 4'd4, 4'd5, 4'd4, 4'd3, 4'd4, 4'd4
    };

    // The command bytes hold the first character in the least significant
    // byte, with zeros above the stored length.
    function automatic logic [4:0] match_command(logic [63:0] cmd_bytes,
                                                 logic [3:0] cmd_len,
                                                 logic cmd_too_long);
        logic [4:0]  code;
        logic [63:0] expect_bytes;
        int          idx;
        code = '0;
        if (!cmd_too_long && cmd_len != 4'd0) begin
            for (int w = NUM_WORDS - 1; w >= 0; w--) begin
                expect_bytes = '0;
                for (int k = 0; k < 8; k++) begin
                    if (k < int'(WORD_LEN[w])) begin
                        idx = 8 * (int'(WORD_LEN[w]) - 1 - k);
                        expect_bytes[8*k +: 8] = WORD_TEXT[w][idx +: 8];
                    end
                end
                if (cmd_len == WORD_LEN[w] && cmd_bytes == expect_bytes) begin
                    code = 5'(w + 1);
                end
            end
        end
        return code;
    endfunction

endpackage

FILE: rtl/crlf_line_command_tokenizer.sv
// Top level of the CR LF line command tokenizer: line framing, token
// splitting, command match and the result queue.
// Depends on crlf_tok_pkg.

// The block takes one byte per cycle. Each kept line byte, but a space before the
// trailing part, gives one token byte word tagged with its token number, and CR LF
// gives one end of line summary word with command code, token count, overflow
// and empty-line flags. A CR is held until the next byte; if that byte is not
// LF, the CR and the byte both count as line bytes, which can give two words
// for one input. Words leave through a four-entry queue at one per cycle, so
// input is taken every cycle except when that single output port falls behind
// such double words or the consumer stalls. Bytes past MAX_LINE in a line are
// dropped and reported as overflow.
module crlf_line_command_tokenizer #(
    parameter int MAX_LINE = crlf_tok_pkg::MAX_LINE_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_result_kind,
    output logic [7:0] m_out_byte,
    output logic [8:0] m_token_index,
    output logic [4:0] m_command_code,
    output logic [9:0] m_token_count,
    output logic       m_overflow,
    output logic       m_empty_line,
    output logic       m_last
);

    localparam int LEN_W = $clog2(MAX_LINE + 1);
    localparam int CNT_W = $clog2(crlf_tok_pkg::FIFO_DEPTH + 1);
    localparam int PTR_W = crlf_tok_pkg::PTR_W;

    typedef struct packed {
        logic             in_trailing;
        logic             after_space;
        logic [9:0]       token_number;
        logic [LEN_W-1:0] line_length;
        logic             overflow_seen;
        logic [63:0]      command_bytes;
        logic [3:0]       command_length;
        logic             command_too_long;
    } line_state_t;

    typedef struct packed {
        line_state_t st;
        logic        emit;
        logic [8:0]  tok;
    } feed_t;

    function automatic feed_t feed(line_state_t st, logic [7:0] c);
        feed_t f;
        f.st = st;
        f.emit = 1'b0;
        f.tok = st.token_number[8:0];
        if (st.line_length >= LEN_W'(MAX_LINE)) begin
            f.st.overflow_seen = 1'b1;
        end else begin
            f.st.line_length = st.line_length + 1'b1;
            if (st.in_trailing) begin
                f.emit = 1'b1;
            end else if (c == crlf_tok_pkg::CHAR_SPACE) begin
                f.st.token_number = st.token_number + 1'b1;
                f.st.after_space = 1'b1;
            end else begin
                if (c == crlf_tok_pkg::CHAR_COLON && st.after_space) begin
                    f.st.in_trailing = 1'b1;
                end
                f.st.after_space = 1'b0;
                if (st.token_number == 10'd0) begin
                    if (st.command_length < 4'd8) begin
                        f.st.command_bytes[{st.command_length[2:0], 3'b000} +: 8] = c;
                        f.st.command_length = st.command_length + 1'b1;
                    end else begin
                        f.st.command_too_long = 1'b1;
                    end
                end
                f.emit = 1'b1;
            end
        end
        return f;
    endfunction

    function automatic crlf_tok_pkg::result_t byte_word(logic [7:0] c, logic [8:0] tok);
        crlf_tok_pkg::result_t r;
        r = '0;
        r.result_kind = crlf_tok_pkg::KIND_BYTE;
        r.out_byte = c;
        r.token_index = tok;
        return r;
    endfunction

    line_state_t line_reg, line_next;
    logic        pending_cr_reg, pending_cr_next;

    crlf_tok_pkg::result_t fifo_reg [crlf_tok_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]      count_reg, count_next;

    crlf_tok_pkg::result_t word0, word1;
    logic [1:0]            n_words;
    logic                  s_fire, m_fire;
    feed_t                 feed_cr, feed_b;
    line_state_t           st_mid;
    logic                  line_done;

    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;
    assign s_ready = count_reg <= CNT_W'(crlf_tok_pkg::FIFO_DEPTH - 2);

    always_comb begin
        line_done = pending_cr_reg && (s_data_byte == crlf_tok_pkg::CHAR_LF);
        feed_cr = feed(line_reg, crlf_tok_pkg::CHAR_CR);
        st_mid = pending_cr_reg ? feed_cr.st : line_reg;
        feed_b = feed(st_mid, s_data_byte);
        word0 = '0;
        word1 = '0;
        n_words = 2'd0;
        line_next = line_reg;
        pending_cr_next = pending_cr_reg;
        if (line_done) begin
            word0.result_kind = crlf_tok_pkg::KIND_SUMMARY;
            word0.empty_line = (line_reg.line_length == '0);
            if (line_reg.line_length != '0) begin
                word0.command_code = crlf_tok_pkg::match_command(
                    line_reg.command_bytes, line_reg.command_length,
                    line_reg.command_too_long);
                word0.token_count = line_reg.after_space ? line_reg.token_number
                                                         : line_reg.token_number + 1'b1;
            end
            word0.overflow = line_reg.overflow_seen;
            word0.last = 1'b1;
            n_words = 2'd1;
            line_next = '0;
            pending_cr_next = 1'b0;
        end else begin
            if (pending_cr_reg && feed_cr.emit) begin
                word0 = byte_word(crlf_tok_pkg::CHAR_CR, feed_cr.tok);
                n_words = 2'd1;
            end
            if (s_data_byte == crlf_tok_pkg::CHAR_CR) begin
                pending_cr_next = 1'b1;
                line_next = st_mid;
            end else begin
                pending_cr_next = 1'b0;
                line_next = feed_b.st;
                if (feed_b.emit) begin
                    if (n_words == 2'd0) begin
                        word0 = byte_word(s_data_byte, feed_b.tok);
                    end else begin
                        word1 = byte_word(s_data_byte, feed_b.tok);
                    end
                    n_words = n_words + 2'd1;
                end
            end
            if (n_words == 2'd1) begin
                word0.last = 1'b1;
            end else if (n_words == 2'd2) begin
                word1.last = 1'b1;
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (s_fire) begin
            count_next = count_next + CNT_W'(n_words);
        end
        if (m_fire) begin
            count_next = count_next - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg <= '0;
            pending_cr_reg <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (s_fire) begin
                line_reg <= line_next;
                pending_cr_reg <= pending_cr_next;
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(n_words);
            end
            if (m_fire) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && n_words != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= word0;
        end
        if (s_fire && n_words == 2'd2) begin
            fifo_reg[wr_ptr_reg + 1'b1] <= word1;
        end
    end

    assign m_valid = count_reg != '0;
    assign m_result_kind = fifo_reg[rd_ptr_reg].result_kind;
    assign m_out_byte = fifo_reg[rd_ptr_reg].out_byte;
    assign m_token_index = fifo_reg[rd_ptr_reg].token_index;
    assign m_command_code = fifo_reg[rd_ptr_reg].command_code;
    assign m_token_count = fifo_reg[rd_ptr_reg].token_count;
    assign m_overflow = fifo_reg[rd_ptr_reg].overflow;
    assign m_empty_line = fifo_reg[rd_ptr_reg].empty_line;
    assign m_last = fifo_reg[rd_ptr_reg].last;

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(crlf_tok_pkg::FIFO_DEPTH))
        else $error("result queue count beyond its depth");

    a_line_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        line_reg.line_length <= LEN_W'(MAX_LINE))
        else $error("line length beyond maximum");

    a_line_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && pending_cr_reg && s_data_byte == crlf_tok_pkg::CHAR_LF)
        |=> (line_reg.line_length == '0 && !pending_cr_reg && m_valid))
        else $error("line state not cleared after CR LF");

    a_cr_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data_byte == crlf_tok_pkg::CHAR_CR) |=> pending_cr_reg)
        else $error("CR not held");

endmodule

FILE: sim/crlf_line_command_tokenizer_tb.sv
// Self-checking testbench for the CR LF line command tokenizer: directed corner
// lines and random byte streams of command lines and noise, checked word by word against a predictor.
// Depends on crlf_tok_pkg and crlf_line_command_tokenizer.
`timescale 1ns / 100ps

module crlf_line_command_tokenizer_tb;

    localparam int LINE_LIMIT = crlf_tok_pkg::MAX_LINE_DEFAULT;
    localparam int STREAM_TARGET = 1750;
    localparam int LONG_STALL = 200;
    localparam int DRAIN_CYCLES = 20;

    logic       aclk;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_result_kind;
    logic [7:0] m_out_byte;
    logic [8:0] m_token_index;
    logic [4:0] m_command_code;
    logic [9:0] m_token_count;
    logic       m_overflow;
    logic       m_empty_line;
    logic       m_last;

    string command_names [crlf_tok_pkg::NUM_WORDS] = '{
        "NICK", "USER", "PRIVMSG", "NOTICE", "MOTD", "LUSERS", "PING", "PONG",
        "WHOIS", "QUIT", "JOIN", "PART", "TOPIC", "AWAY", "NAMES", "LIST",
        "WHO", "OPER", "MODE"
    };

    logic [7:0]            pending_bytes [$];
    crlf_tok_pkg::result_t expected_words [$];

    // Predicted line state.
    logic        cr_held = 1'b0;
    logic        rest_of_line = 1'b0;
    logic        follows_space = 1'b0;
    logic [9:0]  tok_num = '0;
    logic [9:0]  line_len = '0;
    logic        ovf_seen = 1'b0;
    logic [63:0] cmd_word = '0;
    logic [3:0]  cmd_len = '0;
    logic        cmd_overlong = 1'b0;
    int          new_words;

    int unsigned bytes_sent = 0;
    int unsigned lines_queued = 0;
    int unsigned words_checked = 0;
    int unsigned summaries_checked = 0;
    int unsigned overflow_lines = 0;
    int unsigned error_count = 0;
    logic [31:0] codes_seen = '0;
    int          send_gap = 0;
    int          stall_left = 0;
    int unsigned next_long_stall = 150;

    crlf_line_command_tokenizer #(
        .MAX_LINE(LINE_LIMIT)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data_byte(s_data_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_result_kind(m_result_kind),
        .m_out_byte(m_out_byte),
        .m_token_index(m_token_index),
        .m_command_code(m_command_code),
        .m_token_count(m_token_count),
        .m_overflow(m_overflow),
        .m_empty_line(m_empty_line),
        .m_last(m_last)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic logic [4:0] command_lookup();
        logic [4:0] code;
        logic       same;
        code = '0;
        if (!cmd_overlong && cmd_len != 4'd0) begin
            for (int i = 0; i < crlf_tok_pkg::NUM_WORDS && code == 5'd0; i++) begin
                if (command_names[i].len() == int'(cmd_len)) begin
                    same = 1'b1;
                    for (int k = 0; k < command_names[i].len(); k++) begin
                        if (cmd_word[8*k +: 8] != command_names[i][k]) same = 1'b0;
                    end
                    if (same) code = 5'(i + 1);
                end
            end
        end
        return code;
    endfunction

    function automatic void feed_line_byte(input logic [7:0] c);
        crlf_tok_pkg::result_t w;
        if (line_len >= LINE_LIMIT) begin
            ovf_seen = 1'b1;
            return;
        end
        line_len++;
        if (!rest_of_line) begin
            if (c == crlf_tok_pkg::CHAR_SPACE) begin
                tok_num++;
                follows_space = 1'b1;
                return;
            end
            if (c == crlf_tok_pkg::CHAR_COLON && follows_space) rest_of_line = 1'b1;
            follows_space = 1'b0;
            if (tok_num == 10'd0) begin
                if (cmd_len < 4'd8) begin
                    cmd_word[8*cmd_len +: 8] = c;
                    cmd_len++;
                end else begin
                    cmd_overlong = 1'b1;
                end
            end
        end
        w = '0;
        w.result_kind = crlf_tok_pkg::KIND_BYTE;
        w.out_byte = c;
        w.token_index = tok_num[8:0];
        expected_words.push_back(w);
        new_words++;
    endfunction

    function automatic void predict_byte(input logic [7:0] b);
        crlf_tok_pkg::result_t w;
        new_words = 0;
        if (cr_held) begin
            cr_held = 1'b0;
            if (b == crlf_tok_pkg::CHAR_LF) begin
                w = '0;
                w.result_kind = crlf_tok_pkg::KIND_SUMMARY;
                w.empty_line = (line_len == 10'd0);
                if (!w.empty_line) begin
                    w.command_code = command_lookup();
                    w.token_count = follows_space ? tok_num : tok_num + 10'd1;
                end
                w.overflow = ovf_seen;
                w.last = 1'b1;
                expected_words.push_back(w);
                rest_of_line = 1'b0;
                follows_space = 1'b0;
                tok_num = '0;
                line_len = '0;
                ovf_seen = 1'b0;
                cmd_word = '0;
                cmd_len = '0;
                cmd_overlong = 1'b0;
                return;
            end
            feed_line_byte(crlf_tok_pkg::CHAR_CR);
        end
        if (b == crlf_tok_pkg::CHAR_CR) cr_held = 1'b1;
        else feed_line_byte(b);
        if (new_words != 0) begin
            w = expected_words.pop_back();
            w.last = 1'b1;
            expected_words.push_back(w);
        end
    endfunction

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            error_count++;
            $display("%0t: word %0d field %s expected %0d, got %0d",
                     $time, words_checked, name, want, got);
        end
    endfunction

    function automatic void check_word();
        crlf_tok_pkg::result_t want;
        crlf_tok_pkg::result_t got;
        got = {m_result_kind, m_out_byte, m_token_index, m_command_code,
               m_token_count, m_overflow, m_empty_line, m_last};
        words_checked++;
        if (expected_words.size() == 0) begin
            error_count++;
            $display("%0t: word %0d expected nothing, got %h",
                     $time, words_checked, got);
            return;
        end
        want = expected_words.pop_front();
        compare_field("result_kind", want.result_kind, got.result_kind);
        compare_field("out_byte", want.out_byte, got.out_byte);
        compare_field("token_index", want.token_index, got.token_index);
        compare_field("command_code", want.command_code, got.command_code);
        compare_field("token_count", want.token_count, got.token_count);
        compare_field("overflow", want.overflow, got.overflow);
        compare_field("empty_line", want.empty_line, got.empty_line);
        compare_field("last", want.last, got.last);
        if (want.result_kind == crlf_tok_pkg::KIND_SUMMARY) begin
            summaries_checked++;
            if (want.overflow) overflow_lines++;
            codes_seen[want.command_code] = 1'b1;
        end
    endfunction

    function automatic logic [7:0] content_char();
        logic [7:0] ch;
        if ($urandom_range(0, 99) < 85) return 8'($urandom_range(8'h21, 8'h7E));
        ch = 8'($urandom_range(0, 255));
        if (ch == crlf_tok_pkg::CHAR_CR || ch == crlf_tok_pkg::CHAR_SPACE) ch = ch | 8'h80;
        return ch;
    endfunction

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
    endtask

    task automatic queue_crlf();
        pending_bytes.push_back(crlf_tok_pkg::CHAR_CR);
        pending_bytes.push_back(crlf_tok_pkg::CHAR_LF);
    endtask

    task automatic queue_random_line();
        logic [7:0] line_bytes [$];
        int         kind;
        int         n_params;
        int         idx;
        string      cmd;
        kind = $urandom_range(0, 99);
        cmd = command_names[$urandom_range(0, crlf_tok_pkg::NUM_WORDS - 1)];
        if (kind < 80) begin
            for (int k = 0; k < cmd.len(); k++) line_bytes.push_back(cmd[k]);
            if (kind >= 55 && kind < 70) begin
                idx = $urandom_range(0, line_bytes.size() - 1);
                line_bytes[idx] = line_bytes[idx] ^ 8'h20;
            end else if (kind >= 70 && kind < 75) begin
                void'(line_bytes.pop_back());
            end else if (kind >= 75) begin
                repeat ($urandom_range(1, 6)) line_bytes.push_back(content_char());
            end
        end else if (kind < 92) begin
            repeat ($urandom_range(1, 10)) line_bytes.push_back(content_char());
        end
        n_params = $urandom_range(0, 4);
        for (int p = 0; p < n_params; p++) begin
            line_bytes.push_back(crlf_tok_pkg::CHAR_SPACE);
            if ($urandom_range(0, 9) == 0) line_bytes.push_back(crlf_tok_pkg::CHAR_SPACE);
            if (p == n_params - 1 && $urandom_range(0, 99) < 25) begin
                line_bytes.push_back(crlf_tok_pkg::CHAR_COLON);
                repeat ($urandom_range(0, 10)) begin
                    if ($urandom_range(0, 3) == 0) begin
                        line_bytes.push_back(crlf_tok_pkg::CHAR_SPACE);
                    end else begin
                        line_bytes.push_back(content_char());
                    end
                end
            end else begin
                repeat ($urandom_range(0, 6)) line_bytes.push_back(content_char());
            end
            if ($urandom_range(0, 9) == 0) begin
                line_bytes.push_back(crlf_tok_pkg::CHAR_CR);
                line_bytes.push_back(content_char());
            end
        end
        if ($urandom_range(0, 9) == 0) line_bytes.push_back(crlf_tok_pkg::CHAR_SPACE);
        foreach (line_bytes[i]) pending_bytes.push_back(line_bytes[i]);
        queue_crlf();
        lines_queued++;
    endtask

    task automatic queue_noise();
        repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(0, 4) == 0) pending_bytes.push_back(crlf_tok_pkg::CHAR_CR);
            else pending_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic queue_long_line();
        repeat (LINE_LIMIT - 1) pending_bytes.push_back(crlf_tok_pkg::CHAR_SPACE);
        queue_text("Z");
        pending_bytes.push_back(crlf_tok_pkg::CHAR_CR);
        queue_text("q");
        queue_crlf();
        lines_queued++;
    endtask

    // Sender: presents queued bytes with random gaps between bytes and gap-free stretches.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else if (!s_valid || s_ready) begin
            if (send_gap != 0) begin
                s_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_bytes.size() != 0) begin
                s_valid <= 1'b1;
                s_data_byte <= pending_bytes.pop_front();
                bytes_sent <= bytes_sent + 1;
                send_gap <= ((bytes_sent / 350) % 4 == 0) ? 0 : random_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, stall-free stretches and a few long hold-offs.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (words_checked >= next_long_stall) begin
            m_ready <= 1'b0;
            stall_left <= LONG_STALL;
            next_long_stall <= next_long_stall + 900;
        end else if ((words_checked / 400) % 3 == 0 || $urandom_range(0, 3) != 0) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b0;
            stall_left <= random_gap();
        end
    end

    // Monitor: predicts on each accepted byte, then checks each accepted word.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) predict_byte(s_data_byte);
            if (m_valid && m_ready) check_word();
        end
    end

    initial begin
        queue_crlf();
        queue_text(" ");
        queue_crlf();
        queue_text("a:");
        pending_bytes.push_back(crlf_tok_pkg::CHAR_CR);
        queue_text("b ");
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(crlf_tok_pkg::CHAR_CR);
        queue_crlf();
        queue_text("WHO  :x ");
        queue_crlf();
        pending_bytes.push_back(crlf_tok_pkg::CHAR_LF);
        queue_long_line();
        while (pending_bytes.size() < STREAM_TARGET) begin
            if ($urandom_range(0, 99) < 82) queue_random_line();
            else queue_noise();
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_bytes.size() != 0 || s_valid) @(posedge aclk);
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d bytes, %0d lines; %0d words checked, %0d summaries, %0d overflowed.",
                 bytes_sent, lines_queued, words_checked, summaries_checked, overflow_lines);
        $display("%0d of %0d command words recognized at least once; %0d field errors.",
                 $countones(codes_seen[crlf_tok_pkg::NUM_WORDS:1]), crlf_tok_pkg::NUM_WORDS,
                 error_count);
        if (error_count == 0) begin
            $display("crlf_line_command_tokenizer: match");
        end else begin
            $display("crlf_line_command_tokenizer: mismatch");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("Timed out with %0d words still expected.", expected_words.size());
        $display("crlf_line_command_tokenizer: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/crlf_tok_pkg.sv
rtl/crlf_line_command_tokenizer.sv
sim/crlf_line_command_tokenizer_tb.sv
